FILE: src/csl_pkg.sv
// Shared types, character codes, keyword table and helpers for the C source lexer.
package csl_pkg;

  // Default sizing
  localparam int unsigned KW_COUNT_DEF     = 32;
  localparam int unsigned KW_MAX_CHARS_DEF = 8;
  localparam int unsigned MAX_COLUMN_DEF   = 4095;
  localparam int unsigned MAX_LINE_DEF     = 65535;

  // Longest keyword in the table, and the table size
  localparam int unsigned KW_TEXT_CHARS = 8;
  localparam int unsigned KW_TABLE_SIZE = 32;
  localparam int unsigned KW_IDX_W      = 5;

  localparam logic [30:0] VAL_CAP = 31'h7FFF_FFFF;
  localparam logic [11:0] LEN_CAP = 12'hFFF;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Token kinds
  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_OPER    = 3'd2,
    KIND_ESCAPE  = 3'd3,
    KIND_INT     = 3'd4,
    KIND_FLOAT   = 3'd5,
    KIND_STRING  = 3'd6,
    KIND_UNTERM  = 3'd7
  } kind_t;

  // Scanner state, one-hot
  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_WORD = 7'b0000010,
    MODE_INT  = 7'b0000100,
    MODE_FRAC = 7'b0001000,
    MODE_STR  = 7'b0010000,
    MODE_OP   = 7'b0100000,
    MODE_ESC  = 7'b1000000
  } mode_t;

  // Keyword lookup result
  typedef struct packed {
    logic                hit;
    logic [KW_IDX_W-1:0] index;
  } kw_result_t;

  // Keyword text, right-justified, first character in the highest used byte
  function automatic logic [8*KW_TEXT_CHARS-1:0] kw_text(input int unsigned k);
    logic [8*KW_TEXT_CHARS-1:0] t;
    case (k)
      0:  t = "auto";
      1:  t = "break";
      2:  t = "case";
      3:  t = "char";
      4:  t = "const";
      5:  t = "continue";
      6:  t = "default";
      7:  t = "do";
      8:  t = "double";
      9:  t = "else";
      10: t = "enum";
      11: t = "extern";
      12: t = "float";
      13: t = "for";
      14: t = "goto";
      15: t = "if";
      16: t = "int";
      17: t = "long";
      18: t = "register";
      19: t = "return";
      20: t = "short";
      21: t = "signed";
      22: t = "sizeof";
      23: t = "static";
      24: t = "struct";
      25: t = "switch";
      26: t = "typedef";
      27: t = "union";
      28: t = "unsigned";
      29: t = "void";
      30: t = "volatile";
      31: t = "while";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic int unsigned kw_len(input int unsigned k);
    logic [8*KW_TEXT_CHARS-1:0] t;
    int unsigned n;
    t = kw_text(k);
    n = 0;
    for (int unsigned i = 0; i < KW_TEXT_CHARS; i++) begin
      if (t[8*i +: 8] != 8'h00) n = i + 1;
    end
    return n;
  endfunction

  // Character i of keyword k, counted from the start of the word
  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
    logic [8*KW_TEXT_CHARS-1:0] t;
    int unsigned n;
    t = kw_text(k);
    n = kw_len(k);
    if (i < n) return t[8*(n-1-i) +: 8];
    return 8'h00;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    logic r;
    case (c)
      CH_QMARK, CH_DOT, CH_HASH, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h25, 8'h26, 8'h5E,
      8'h7C, 8'h21, 8'h3D, 8'h3E, 8'h3C, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D,
      8'h5B, 8'h5D, 8'h3A, 8'h3B: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // + - & | = > <
  function automatic logic is_pair_second(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h26) || (c == 8'h7C) ||
           (c == 8'h3D) || (c == 8'h3E) || (c == 8'h3C);
  endfunction

  function automatic logic [11:0] inc_len(input logic [11:0] v);
    return (v < LEN_CAP) ? v + 12'd1 : LEN_CAP;
  endfunction

  // a * 10 + d, saturating
  function automatic logic [30:0] acc10(input logic [30:0] a, input logic [3:0] d);
    logic [34:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {31'd0, d};
    return (v > {4'd0, VAL_CAP}) ? VAL_CAP : v[30:0];
  endfunction

endpackage

FILE: src/c_source_lexer.sv
// Top level of the C source lexer: byte scanner state and registered token output.
//
//   channel | direction | tdata                 | tuser | tlast
//   in_     | slave     | source byte           | -     | -
//   out_    | master    | token descriptor      | kind  | last word of the byte
//
// One byte is taken per cycle unless stalled; each byte yields at most one token
// word, which appears in the output register the cycle after the byte is taken.
// The scanner state and token fields are worked out in one combinational pass.
// in_tready is low only while the output register is full and out_tready is low.
// rst_n is synchronous, active low; the scanner restarts at line 1, column 0.
module c_source_lexer
  import csl_pkg::*;
#(
  parameter int unsigned KEYWORD_COUNT     = KW_COUNT_DEF,
  parameter int unsigned KEYWORD_MAX_CHARS = KW_MAX_CHARS_DEF,
  parameter int unsigned MAX_COLUMN        = MAX_COLUMN_DEF,
  parameter int unsigned MAX_LINE          = MAX_LINE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: [7:0] ch
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  // out_tdata: [15:0] line_no, [27:16] start_column, [39:28] token_length,
  //   [44:40] keyword_index, [52:45] first_char, [60:53] second_char,
  //   [91:61] int_value, [122:92] frac_value, [134:123] frac_digits, [135] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // out_tuser: [2:0] kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam logic [11:0] COL_CAP  = (MAX_COLUMN < 4095) ? 12'(MAX_COLUMN) : 12'd4095;
  localparam logic [15:0] LINE_CAP = (MAX_LINE < 65535) ? 16'(MAX_LINE) : 16'd65535;
  localparam int unsigned PIDX_W   = $clog2(KEYWORD_MAX_CHARS);

  // scanner state
  mode_t       mode_r,   mode_nxt;
  logic [15:0] line_r,   line_nxt;
  logic [11:0] col_r,    col_nxt;
  logic [11:0] wlen_r,   wlen_nxt;
  logic [11:0] tstart_r, tstart_nxt;
  logic [7:0]  held_r,   held_nxt;
  logic [30:0] iacc_r,   iacc_nxt;
  logic [30:0] facc_r,   facc_nxt;
  logic [11:0] fcnt_r,   fcnt_nxt;
  logic [7:0]  prefix_r [KEYWORD_MAX_CHARS];

  // prefix write port
  logic              pfx_we;
  logic [PIDX_W-1:0] pfx_idx;

  // output register
  logic        out_valid_r;
  kind_t       o_kind_r,  e_kind;
  logic [15:0] o_line_r;
  logic [11:0] o_start_r;
  logic [11:0] o_len_r,   e_len;
  logic [4:0]  o_kw_r,    e_kw;
  logic [7:0]  o_c1_r,    e_c1;
  logic [7:0]  o_c2_r,    e_c2;
  logic [30:0] o_iv_r,    e_iv;
  logic [30:0] o_fv_r,    e_fv;
  logic [11:0] o_fd_r,    e_fd;
  logic        emit;

  logic [7:0]  ch;
  logic        fire;
  logic        again;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] col_inc;

  logic [KW_TEXT_CHARS-1:0][7:0] kw_prefix;
  kw_result_t                    kw_res;

  assign ch        = in_tdata;
  assign in_tready = ~out_valid_r | out_tready;
  assign fire      = in_tvalid & in_tready;
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit     = 4'(ch - CH_ZERO);
  assign col_inc   = (ch != CH_NL && col_r < COL_CAP) ? col_r + 12'd1 : col_r;

  always_comb begin
    for (int i = 0; i < KW_TEXT_CHARS; i++) kw_prefix[i] = prefix_r[i];
  end

  csl_kw_match #(
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_kw_match (
    .prefix   (kw_prefix),
    .word_len (wlen_r),
    .result   (kw_res)
  );

  // next scanner state and token for the byte on the input
  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_inc;
    wlen_nxt   = wlen_r;
    tstart_nxt = tstart_r;
    held_nxt   = held_r;
    iacc_nxt   = iacc_r;
    facc_nxt   = facc_r;
    fcnt_nxt   = fcnt_r;
    pfx_we     = 1'b0;
    pfx_idx    = wlen_r[PIDX_W-1:0];
    again      = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_IDENT;
    e_len      = wlen_r;
    e_kw       = '0;
    e_c1       = '0;
    e_c2       = '0;
    e_iv       = '0;
    e_fv       = '0;
    e_fd       = '0;

    unique case (mode_r)
      MODE_WORD: begin
        if (ch == CH_SPACE || ch == CH_NL || is_op(ch) || ch == CH_BSLASH ||
            ch == CH_QUOTE) begin
          emit   = 1'b1;
          e_kind = kw_res.hit ? KIND_KEYWORD : KIND_IDENT;
          e_kw   = kw_res.hit ? kw_res.index : '0;
          again  = 1'b1;
        end else begin
          pfx_we   = (wlen_r < 12'(KEYWORD_MAX_CHARS));
          wlen_nxt = inc_len(wlen_r);
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          iacc_nxt = acc10(iacc_r, digit);
          wlen_nxt = inc_len(wlen_r);
        end else if (ch == CH_DOT) begin
          mode_nxt = MODE_FRAC;
          wlen_nxt = inc_len(wlen_r);
        end else begin
          emit   = 1'b1;
          e_kind = KIND_INT;
          e_iv   = iacc_r;
          again  = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (is_digit) begin
          facc_nxt = acc10(facc_r, digit);
          fcnt_nxt = inc_len(fcnt_r);
          wlen_nxt = inc_len(wlen_r);
        end else begin
          emit   = 1'b1;
          e_kind = KIND_FLOAT;
          e_iv   = iacc_r;
          e_fv   = facc_r;
          e_fd   = fcnt_r;
          again  = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch == CH_QUOTE) begin
          emit     = 1'b1;
          e_kind   = KIND_STRING;
          mode_nxt = MODE_IDLE;
        end else if (ch == CH_NL) begin
          emit   = 1'b1;
          e_kind = KIND_UNTERM;
          again  = 1'b1;
        end else begin
          wlen_nxt = inc_len(wlen_r);
        end
      end
      MODE_OP: begin
        emit   = 1'b1;
        e_kind = KIND_OPER;
        e_c1   = held_r;
        if (is_pair_second(ch)) begin
          e_len    = 12'd2;
          e_c2     = ch;
          mode_nxt = MODE_IDLE;
        end else begin
          e_len = 12'd1;
          again = 1'b1;
        end
      end
      MODE_ESC: begin
        emit     = 1'b1;
        e_kind   = KIND_ESCAPE;
        e_len    = 12'd2;
        e_c1     = CH_BSLASH;
        e_c2     = ch;
        mode_nxt = MODE_IDLE;
        again    = (ch == CH_NL);
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // start of a new token from idle
    if (again) begin
      mode_nxt = MODE_IDLE;
      if (ch == CH_NL) begin
        if (line_r < LINE_CAP) line_nxt = line_r + 16'd1;
        col_nxt = '0;
      end else if (ch == CH_SPACE) begin
        mode_nxt = MODE_IDLE;
      end else if (is_op(ch)) begin
        mode_nxt   = MODE_OP;
        held_nxt   = ch;
        tstart_nxt = col_inc;
      end else if (ch == CH_BSLASH) begin
        mode_nxt   = MODE_ESC;
        tstart_nxt = col_inc;
      end else if (is_digit) begin
        mode_nxt   = MODE_INT;
        tstart_nxt = col_inc;
        iacc_nxt   = {27'd0, digit};
        facc_nxt   = '0;
        fcnt_nxt   = '0;
        wlen_nxt   = 12'd1;
      end else if (ch == CH_QUOTE) begin
        mode_nxt   = MODE_STR;
        tstart_nxt = (col_inc < COL_CAP) ? col_inc + 12'd1 : COL_CAP;
        wlen_nxt   = '0;
      end else begin
        mode_nxt   = MODE_WORD;
        tstart_nxt = col_inc;
        pfx_we     = 1'b1;
        pfx_idx    = '0;
        wlen_nxt   = 12'd1;
      end
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      line_r   <= 16'd1;
      col_r    <= '0;
      wlen_r   <= '0;
      tstart_r <= '0;
      held_r   <= '0;
      iacc_r   <= '0;
      facc_r   <= '0;
      fcnt_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      wlen_r   <= wlen_nxt;
      tstart_r <= tstart_nxt;
      held_r   <= held_nxt;
      iacc_r   <= iacc_nxt;
      facc_r   <= facc_nxt;
      fcnt_r   <= fcnt_nxt;
    end
  end

  // word prefix buffer, no reset
  always_ff @(posedge clk) begin
    if (fire && pfx_we) prefix_r[pfx_idx] <= ch;
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      o_kind_r  <= e_kind;
      o_line_r  <= line_r;
      o_start_r <= tstart_r;
      o_len_r   <= e_len;
      o_kw_r    <= e_kw;
      o_c1_r    <= e_c1;
      o_c2_r    <= e_c2;
      o_iv_r    <= e_iv;
      o_fv_r    <= e_fv;
      o_fd_r    <= e_fd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = 1'b1;
  assign out_tdata  = {1'b0, o_fd_r, o_fv_r, o_iv_r, o_c2_r, o_c1_r, o_kw_r,
                       o_len_r, o_start_r, o_line_r};

endmodule

FILE: src/csl_kw_match.sv
// Parallel keyword compare of the buffered word prefix against the keyword table.
module csl_kw_match
  import csl_pkg::*;
#(
  parameter int unsigned KEYWORD_COUNT = KW_COUNT_DEF
) (
  input  logic [KW_TEXT_CHARS-1:0][7:0] prefix,
  input  logic [11:0]                   word_len,
  output kw_result_t                    result
);

  localparam int unsigned KW_USED =
    (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

  logic [KW_USED-1:0] hit;

  // one comparator per table entry
  always_comb begin
    for (int unsigned k = 0; k < KW_USED; k++) begin
      hit[k] = (word_len == 12'(kw_len(k)));
      for (int unsigned i = 0; i < KW_TEXT_CHARS; i++) begin
        if (i < kw_len(k) && prefix[i] != kw_char(k, i)) hit[k] = 1'b0;
      end
    end
  end

  // lowest matching index wins
  always_comb begin
    result.hit   = |hit;
    result.index = '0;
    for (int k = KW_USED - 1; k >= 0; k--) begin
      if (hit[k]) result.index = KW_IDX_W'(k);
    end
  end

endmodule
